FILE: hw/rtl/iapr_pkg.sv
// Shared types and constants for the inverse affine pixel remap block.
`default_nettype none

package iapr_pkg;

	// Field widths of the stream items.
	localparam int COL_W       = 13;
	localparam int ROW_W       = 12;
	localparam int DIM_W       = 14;
	localparam int OUT_IDX_W   = 27;
	localparam int SRC_IDX_W   = 28;
	localparam int CHAN_W      = 2;
	localparam int COEF_W      = 32;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 56;

	// Configuration register indexes.
	localparam logic [2:0] REG_X_OFFSET     = 3'd0;
	localparam logic [2:0] REG_X_PER_COLUMN = 3'd1;
	localparam logic [2:0] REG_X_PER_ROW    = 3'd2;
	localparam logic [2:0] REG_Y_OFFSET     = 3'd3;
	localparam logic [2:0] REG_Y_PER_COLUMN = 3'd4;
	localparam logic [2:0] REG_Y_PER_ROW    = 3'd5;
	localparam logic [2:0] REG_SRC_WIDTH    = 3'd6;
	localparam logic [2:0] REG_SRC_HEIGHT   = 3'd7;

	// Transform coefficients and clamped source size.
	typedef struct packed {
		logic signed [COEF_W-1:0] x_off;
		logic signed [COEF_W-1:0] x_col;
		logic signed [COEF_W-1:0] x_row;
		logic signed [COEF_W-1:0] y_off;
		logic signed [COEF_W-1:0] y_col;
		logic signed [COEF_W-1:0] y_row;
		logic [DIM_W-1:0]         width;
		logic [DIM_W-1:0]         height;
	} iapr_coef_t;

	// One pixel leaving the address pipeline, before channel expansion.
	typedef struct packed {
		logic [OUT_IDX_W-1:0] out_lin;
		logic [SRC_IDX_W-1:0] src_lin;
		logic                 inb;
	} iapr_pix_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iapr_cfg.sv
// Configuration register file with source size saturation.
`default_nettype none

module iapr_cfg #(
	parameter int SRC_MAX_DIM = 8192
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [2:0]                cfg_index,
	input  wire logic [31:0]               cfg_data,
	output iapr_pkg::iapr_coef_t           coef
);
	import iapr_pkg::*;

	localparam logic [31:0] MAX_DIM = 32'(SRC_MAX_DIM);

	logic signed [COEF_W-1:0] x_off_q, x_col_q, x_row_q;
	logic signed [COEF_W-1:0] y_off_q, y_col_q, y_row_q;
	logic [DIM_W-1:0]         width_q, height_q;

	// Register writes; every index of the port names a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off_q  <= '0;
			x_col_q  <= 32'sd65536;
			x_row_q  <= '0;
			y_off_q  <= '0;
			y_col_q  <= '0;
			y_row_q  <= 32'sd65536;
			width_q  <= 14'd1024;
			height_q <= 14'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_OFFSET:     x_off_q  <= $signed(cfg_data);
				REG_X_PER_COLUMN: x_col_q  <= $signed(cfg_data);
				REG_X_PER_ROW:    x_row_q  <= $signed(cfg_data);
				REG_Y_OFFSET:     y_off_q  <= $signed(cfg_data);
				REG_Y_PER_COLUMN: y_col_q  <= $signed(cfg_data);
				REG_Y_PER_ROW:    y_row_q  <= $signed(cfg_data);
				REG_SRC_WIDTH:    width_q  <= cfg_data[DIM_W-1:0];
				REG_SRC_HEIGHT:   height_q <= cfg_data[DIM_W-1:0];
			endcase
		end
	end

	// Saturate the source size to the largest supported dimension.
	always_comb begin
		coef.x_off  = x_off_q;
		coef.x_col  = x_col_q;
		coef.x_row  = x_row_q;
		coef.y_off  = y_off_q;
		coef.y_col  = y_col_q;
		coef.y_row  = y_row_q;
		coef.width  = ({18'b0, width_q} > MAX_DIM) ? MAX_DIM[DIM_W-1:0] : width_q;
		coef.height = ({18'b0, height_q} > MAX_DIM) ? MAX_DIM[DIM_W-1:0] : height_q;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/iapr_datapath.sv
// Five-stage address pipeline: clamp, multiply, sum, bounds test, source index.
`default_nettype none

module iapr_datapath #(
	parameter int OUT_WIDTH  = 6000,
	parameter int OUT_HEIGHT = 4000
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          in_valid,
	input  wire logic [iapr_pkg::COL_W-1:0]    in_col,
	input  wire logic [iapr_pkg::ROW_W-1:0]    in_row,
	input  wire iapr_pkg::iapr_coef_t          coef,
	output logic                               pix_valid,
	output iapr_pkg::iapr_pix_t                pix
);
	import iapr_pkg::*;

	localparam logic [31:0] COL_MAX = 32'(OUT_WIDTH - 1);
	localparam logic [31:0] ROW_MAX = 32'(OUT_HEIGHT - 1);
	localparam logic [31:0] OUT_W32 = 32'(OUT_WIDTH);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [COL_W-1:0]        col_c;
	logic [ROW_W-1:0]        row_c;
	logic [COL_W-1:0]        col_s1;
	logic [ROW_W-1:0]        row_s1;
	logic [DIM_W-1:0]        flip_s1;

	logic signed [45:0]      xc_s2, xr_s2, yc_s2, yr_s2;
	logic [OUT_IDX_W-1:0]    out_lin_s2;
	logic [31:0]             out_prod;

	logic signed [47:0]      x_s3, y_s3;
	logic [OUT_IDX_W-1:0]    out_lin_s3;

	logic signed [47:0]      x_lim, y_lim, t_y;
	logic                    inb;
	logic [DIM_W-1:0]        hm1;
	logic                    inb_s4;
	logic [DIM_W-1:0]        sx_s4, sy_s4;
	logic [OUT_IDX_W-1:0]    out_lin_s4;

	logic                    inb_s5;
	logic [SRC_IDX_W-1:0]    src_lin_s5;
	logic [OUT_IDX_W-1:0]    out_lin_s5;

	// Valid bits advance with the data under the common enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: saturate the pixel position to the output raster, flip the row.
	always_comb begin
		col_c = ({19'b0, in_col} > COL_MAX) ? COL_MAX[COL_W-1:0] : in_col;
		row_c = ({20'b0, in_row} > ROW_MAX) ? ROW_MAX[ROW_W-1:0] : in_row;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1  <= col_c;
			row_s1  <= row_c;
			flip_s1 <= ROW_MAX[DIM_W-1:0] - {{(DIM_W-ROW_W){1'b0}}, row_c};
		end
	end

	// Stage 2: the four coefficient products and the output linear index.
	assign out_prod = OUT_W32 * {18'b0, flip_s1};

	always_ff @(posedge clk) begin
		if (adv) begin
			xc_s2      <= $signed(coef.x_col) * $signed({1'b0, col_s1});
			xr_s2      <= $signed(coef.x_row) * $signed({1'b0, row_s1});
			yc_s2      <= $signed(coef.y_col) * $signed({1'b0, col_s1});
			yr_s2      <= $signed(coef.y_row) * $signed({1'b0, row_s1});
			out_lin_s2 <= OUT_IDX_W'(out_prod + {19'b0, col_s1});
		end
	end

	// Stage 3: exact source position in Q16.16.
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3       <= $signed(coef.x_off) + xc_s2 + xr_s2;
			y_s3       <= $signed(coef.y_off) + yc_s2 + yr_s2;
			out_lin_s3 <= out_lin_s2;
		end
	end

	// Stage 4: open-rectangle test and truncation of both coordinates.
	always_comb begin
		hm1   = coef.height - 14'd1;
		x_lim = $signed({18'b0, coef.width, 16'b0});
		y_lim = $signed({18'b0, coef.height, 16'b0});
		t_y   = $signed({18'b0, hm1, 16'b0}) - y_s3;
		inb   = (x_s3 > 48'sd0) && (x_s3 < x_lim) && (y_s3 > 48'sd0) && (y_s3 < y_lim);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inb_s4     <= inb;
			sx_s4      <= x_s3[29:16];
			// A row just below the top edge truncates toward zero to row 0.
			sy_s4      <= t_y[47] ? '0 : t_y[29:16];
			out_lin_s4 <= out_lin_s3;
		end
	end

	// Stage 5: linear source pixel index.
	always_ff @(posedge clk) begin
		if (adv) begin
			inb_s5     <= inb_s4;
			src_lin_s5 <= ({14'b0, sy_s4} * {14'b0, coef.width}) + {14'b0, sx_s4};
			out_lin_s5 <= out_lin_s4;
		end
	end

	assign pix_valid   = v_s5;
	assign pix.out_lin = out_lin_s5;
	assign pix.src_lin = src_lin_s5;
	assign pix.inb     = inb_s5;

endmodule

`default_nettype wire

FILE: hw/rtl/iapr_expand.sv
// Channel expander: turns one pixel into one result transaction per channel.
`default_nettype none

module iapr_expand #(
	parameter int CHANNELS = 3
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              pix_valid,
	input  wire iapr_pkg::iapr_pix_t               pix,
	output logic                                   pix_ready,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output logic [iapr_pkg::OUT_IDX_W-1:0]         out_index,
	output logic [iapr_pkg::SRC_IDX_W-1:0]         src_index,
	output logic                                   in_bounds,
	output logic [iapr_pkg::CHAN_W-1:0]            channel,
	output logic                                   last
);
	import iapr_pkg::*;

	localparam logic [CHAN_W-1:0] LAST_CH = CHAN_W'(CHANNELS - 1);

	logic                 vld_q;
	logic [CHAN_W-1:0]    ch_q;
	logic [OUT_IDX_W-1:0] out_idx_q;
	logic [SRC_IDX_W-1:0] src_idx_q;
	logic                 inb_q;
	logic                 last_ch;

	assign last_ch   = (ch_q == LAST_CH);
	assign pix_ready = !vld_q || (res_ready && last_ch);

	// Control: hold a pixel until its final channel has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			ch_q  <= '0;
		end else if (pix_ready) begin
			vld_q <= pix_valid;
			ch_q  <= '0;
		end else if (res_ready) begin
			ch_q  <= ch_q + 1'b1;
		end
	end

	// Indexes start at the channel-zero sample and step by one per channel; an out-of-bounds source index stays zero.
	always_ff @(posedge clk) begin
		if (pix_ready) begin
			out_idx_q <= OUT_IDX_W'(OUT_IDX_W'(CHANNELS) * pix.out_lin);
			src_idx_q <= pix.inb ? SRC_IDX_W'(SRC_IDX_W'(CHANNELS) * pix.src_lin) : '0;
			inb_q     <= pix.inb;
		end else if (res_ready) begin
			out_idx_q <= out_idx_q + 1'b1;
			if (inb_q) begin
				src_idx_q <= src_idx_q + 1'b1;
			end
		end
	end

	assign res_valid = vld_q;
	assign out_index = out_idx_q;
	assign src_index = src_idx_q;
	assign in_bounds = inb_q;
	assign channel   = ch_q;
	assign last      = last_ch;

endmodule

`default_nettype wire

FILE: hw/rtl/inverse_affine_pixel_remap_top.sv
// Top level of the inverse affine nearest-neighbour pixel remap block.
`default_nettype none

// Each output pixel (column, row) on the input stream is mapped through the
// six Q16.16 coefficients to a source position, tested against the open source
// rectangle and turned into CHANNELS result transactions, one per colour
// channel, in channel order with tlast on the final one. A pixel occupies the
// output for its CHANNELS results (three by default), one result per cycle
// while m_tready is high; the channel expander sets the sustained rate, while
// the five-stage address pipeline in front of it accepts a new pixel in any
// cycle in which it can move. A first result leaves after the five address
// stages and the expander's output register. Configuration writes are taken
// at once and must only be made while no pixel is in flight.
module inverse_affine_pixel_remap_top #(
	parameter int OUT_WIDTH   = 6000,
	parameter int OUT_HEIGHT  = 4000,
	parameter int CHANNELS    = 3,
	parameter int SRC_MAX_DIM = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// out_column [12:0], out_row [24:13], zero fill [31:25]
	input  wire logic [iapr_pkg::S_TDATA_W-1:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_index [26:0], src_index [54:27], in_bounds [55]
	output logic [iapr_pkg::M_TDATA_W-1:0] m_tdata,
	// channel [1:0]
	output logic [iapr_pkg::CHAN_W-1:0]    m_tuser,
	output logic             m_tlast
);
	import iapr_pkg::*;

	iapr_coef_t           coef;
	iapr_pix_t            pix;
	logic                 pix_valid;
	logic                 pix_ready;
	logic                 adv;
	logic [OUT_IDX_W-1:0] out_index;
	logic [SRC_IDX_W-1:0] src_index;
	logic                 in_bounds;

	// The pipeline moves whenever its last stage is empty or being drained.
	assign adv      = !pix_valid || pix_ready;
	assign s_tready = adv;

	iapr_cfg #(
		.SRC_MAX_DIM(SRC_MAX_DIM)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	iapr_datapath #(
		.OUT_WIDTH  (OUT_WIDTH),
		.OUT_HEIGHT (OUT_HEIGHT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.in_col    (s_tdata[COL_W-1:0]),
		.in_row    (s_tdata[COL_W+ROW_W-1:COL_W]),
		.coef      (coef),
		.pix_valid (pix_valid),
		.pix       (pix)
	);

	iapr_expand #(
		.CHANNELS(CHANNELS)
	) u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix       (pix),
		.pix_ready (pix_ready),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.out_index (out_index),
		.src_index (src_index),
		.in_bounds (in_bounds),
		.channel   (m_tuser),
		.last      (m_tlast)
	);

	assign m_tdata = {in_bounds, src_index, out_index};

endmodule

`default_nettype wire

FILE: hw/rtl/iapr_checker.sv
// Port-level assertions for the remap block and their binding to the top level.
`default_nettype none

module iapr_checker #(
	parameter int CHANNELS = 3
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [iapr_pkg::M_TDATA_W-1:0]     m_tdata,
	input wire logic [iapr_pkg::CHAN_W-1:0]        m_tuser,
	input wire logic                               m_tlast
);
	import iapr_pkg::*;

	localparam logic [CHAN_W-1:0] LAST_CH = CHAN_W'(CHANNELS - 1);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// tlast marks exactly the final channel.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == LAST_CH)))
		else $error("tlast does not match the final channel");

	// Within a pixel the next result follows at once with the next channel
	// and the next output sample.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tuser == CHAN_W'($past(m_tuser) + 1'b1)) &&
			(m_tdata[OUT_IDX_W-1:0] == OUT_IDX_W'($past(m_tdata[OUT_IDX_W-1:0]) + 1'b1)))
		else $error("channel sequence broken within a pixel");

	// An out-of-bounds result carries a zero source index.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[M_TDATA_W-1] |->
			(m_tdata[OUT_IDX_W+SRC_IDX_W-1:OUT_IDX_W] == '0))
		else $error("source index not zero outside the source image");

endmodule

bind inverse_affine_pixel_remap_top iapr_checker #(
	.CHANNELS(CHANNELS)
) u_iapr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

FILE: bench/remap_result_checker.sv
// Checker that predicts and compares the channel results of the pixel remap block.
`default_nettype none

module remap_result_checker #(
	parameter int OUT_WIDTH   = 6000,
	parameter int OUT_HEIGHT  = 4000,
	parameter int CHANNELS    = 3,
	parameter int SRC_MAX_DIM = 8192
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [31:0]                    cfg_data,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	// out_column [12:0], out_row [24:13], zero fill [31:25]
	input  wire logic [iapr_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	// out_index [26:0], src_index [54:27], in_bounds [55]
	input  wire logic [iapr_pkg::M_TDATA_W-1:0] m_tdata,
	// channel [1:0]
	input  wire logic [iapr_pkg::CHAN_W-1:0]    m_tuser,
	input  wire logic                           m_tlast,
	output int                                  fail_count,
	output int                                  results_checked,
	output int                                  pending
);
	import iapr_pkg::*;

	// One channel result as it leaves the block.
	typedef struct packed {
		logic [OUT_IDX_W-1:0] out_index;
		logic [SRC_IDX_W-1:0] src_index;
		logic                 in_bounds;
		logic [CHAN_W-1:0]    channel;
		logic                 last;
	} channel_result_t;

	// Own copy of the transform and source size.
	logic signed [COEF_W-1:0] x_off, x_col, x_row, y_off, y_col, y_row;
	logic [DIM_W-1:0]         src_width, src_height;

	channel_result_t awaited_results[$];
	channel_result_t want, got;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		fail_count++;
	endtask

	// Maps one output pixel to its source sample and queues one result per channel.
	function automatic void predict_channel_results(input logic [COL_W-1:0] col_in,
			input logic [ROW_W-1:0] row_in);
		longint col, row, w, h, x, y, t, sx, sy, out_base, src_base;
		bit inb;
		channel_result_t r;
		// Positions beyond the output raster are pinned to its last column or row.
		col = (col_in > OUT_WIDTH - 1) ? OUT_WIDTH - 1 : col_in;
		row = (row_in > OUT_HEIGHT - 1) ? OUT_HEIGHT - 1 : row_in;
		w = (src_width > SRC_MAX_DIM) ? SRC_MAX_DIM : src_width;
		h = (src_height > SRC_MAX_DIM) ? SRC_MAX_DIM : src_height;
		// Exact Q16.16 source position, wide enough never to overflow.
		x = longint'(x_off) + longint'(x_col) * col + longint'(x_row) * row;
		y = longint'(y_off) + longint'(y_col) * col + longint'(y_row) * row;
		inb = x > 0 && x < (w <<< 16) && y > 0 && y < (h <<< 16);
		src_base = 0;
		if (inb) begin
			sx = x >>> 16;
			t = ((h - 1) <<< 16) - y;
			// Just below the top edge the flipped row truncates toward zero, giving row 0.
			sy = (t < 0) ? 0 : (t >>> 16);
			src_base = CHANNELS * (sx + w * sy);
		end
		out_base = CHANNELS * (col + OUT_WIDTH * (OUT_HEIGHT - 1 - row));
		for (int k = 0; k < CHANNELS; k++) begin
			r.out_index = OUT_IDX_W'(out_base + k);
			r.src_index = inb ? SRC_IDX_W'(src_base + k) : '0;
			r.in_bounds = inb;
			r.channel   = CHAN_W'(k);
			r.last      = (k == CHANNELS - 1);
			awaited_results.push_back(r);
		end
	endfunction

	// Follows configuration, predicts on each pixel transaction and checks each result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off      = '0;
			x_col      = 32'sd65536;
			x_row      = '0;
			y_off      = '0;
			y_col      = '0;
			y_row      = 32'sd65536;
			src_width  = DIM_W'(1024);
			src_height = DIM_W'(1024);
			awaited_results.delete();
			fail_count      = 0;
			results_checked = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_X_OFFSET:     x_off = cfg_data;
					REG_X_PER_COLUMN: x_col = cfg_data;
					REG_X_PER_ROW:    x_row = cfg_data;
					REG_Y_OFFSET:     y_off = cfg_data;
					REG_Y_PER_COLUMN: y_col = cfg_data;
					REG_Y_PER_ROW:    y_row = cfg_data;
					REG_SRC_WIDTH:    src_width = cfg_data[DIM_W-1:0];
					REG_SRC_HEIGHT:   src_height = cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_channel_results(s_tdata[COL_W-1:0], s_tdata[COL_W+ROW_W-1:COL_W]);
			end
			// Each result transaction is matched against the oldest prediction.
			if (m_tvalid && m_tready) begin
				got.out_index = m_tdata[OUT_IDX_W-1:0];
				got.src_index = m_tdata[OUT_IDX_W+SRC_IDX_W-1:OUT_IDX_W];
				got.in_bounds = m_tdata[OUT_IDX_W+SRC_IDX_W];
				got.channel   = m_tuser;
				got.last      = m_tlast;
				results_checked++;
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("result with out_index %0d arrived with none awaited",
						got.out_index));
				end else begin
					want = awaited_results.pop_front();
					if (got.out_index !== want.out_index)
						report_mismatch($sformatf("out_index expected %0d, got %0d",
							want.out_index, got.out_index));
					if (got.src_index !== want.src_index)
						report_mismatch($sformatf("out_index %0d: src_index expected %0d, got %0d",
							want.out_index, want.src_index, got.src_index));
					if (got.in_bounds !== want.in_bounds)
						report_mismatch($sformatf("out_index %0d: in_bounds expected %0b, got %0b",
							want.out_index, want.in_bounds, got.in_bounds));
					if (got.channel !== want.channel)
						report_mismatch($sformatf("out_index %0d: channel expected %0d, got %0d",
							want.out_index, want.channel, got.channel));
					if (got.last !== want.last)
						report_mismatch($sformatf("out_index %0d: last expected %0b, got %0b",
							want.out_index, want.last, got.last));
				end
			end
			pending <= awaited_results.size();
		end
	end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench top for the pixel remap block: stimulus, idling and the verdict.
`default_nettype none

module tb;
	import iapr_pkg::*;

	// All eight registers, in the order they are written.
	typedef logic [0:7][31:0] reg_set_t;

	localparam logic [2:0] REG_ORDER [8] = '{REG_X_OFFSET, REG_X_PER_COLUMN, REG_X_PER_ROW,
		REG_Y_OFFSET, REG_Y_PER_COLUMN, REG_Y_PER_ROW, REG_SRC_WIDTH, REG_SRC_HEIGHT};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [2:0]           cfg_index;
	logic [31:0]          cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [CHAN_W-1:0]    m_tuser;
	logic                 m_tlast;

	int fail_count;
	int results_checked;
	int pending;
	int pixels_sent;
	int settings_used;
	bit no_idle;

	inverse_affine_pixel_remap_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	remap_result_checker u_result_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.fail_count     (fail_count),
		.results_checked(results_checked),
		.pending        (pending)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Result side: a random stall before each result transaction, none in busy stretches.
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Writes every register; only called while no pixel is in flight.
	task automatic program_transform(input reg_set_t vals);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Offers one pixel after a random gap and waits for its transaction.
	task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - COL_W - ROW_W){1'b0}}, row, col};
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	// Stops offering pixels and waits until every predicted result has come back.
	task automatic await_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Mostly plausible transforms that land many pixels in the source, some pure noise.
	function automatic reg_set_t random_transform();
		reg_set_t v;
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < 8; i++) v[i] = $urandom;
		end else begin
			v[0] = $urandom_range(0, 32'h2000_0000) - 32'h0800_0000;
			v[1] = $urandom_range(0, 196608) - 98304;
			v[2] = $urandom_range(0, 196608) - 98304;
			v[3] = $urandom_range(0, 32'h2000_0000) - 32'h0800_0000;
			v[4] = $urandom_range(0, 196608) - 98304;
			v[5] = $urandom_range(0, 196608) - 98304;
			v[6] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) :
				$urandom_range(256, 8192);
			v[7] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383) :
				$urandom_range(256, 8192);
		end
		return v;
	endfunction

	// Stimulus: directed corners first, then random transforms with random pixels.
	initial begin
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		int pick;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_X_OFFSET;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		pixels_sent   = 0;
		settings_used = 1;
		no_idle       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Identity transform after reset: origin on the open edge, corners, saturation.
		send_pixel(0, 0);
		send_pixel(1, 1);
		send_pixel(1023, 1023);
		send_pixel(1024, 7);
		send_pixel(5999, 3999);
		send_pixel(8191, 4095);
		await_drain();

		// Half-pixel offsets on a 16 by 16 source; the top row lands just below the edge.
		program_transform({32'h0000_8000, 32'h0001_0000, 32'h0, 32'h0000_8000,
			32'h0, 32'h0001_0000, 32'd16, 32'd16});
		send_pixel(0, 0);
		send_pixel(15, 15);
		send_pixel(16, 15);
		send_pixel(3, 16);
		await_drain();

		// Extreme coefficients and oversized source dimensions.
		program_transform({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'd16383, 32'd16383});
		send_pixel(0, 0);
		send_pixel(5999, 0);
		send_pixel(0, 3999);
		send_pixel(5999, 3999);
		await_drain();

		// Largest source with a shear that keeps the whole raster in bounds.
		program_transform({32'h0000_8000, 32'h0001_0000, 32'h0000_8000, 32'h0000_8000,
			32'h0000_8000, 32'h0001_0000, 32'd8192, 32'd8192});
		send_pixel(0, 0);
		send_pixel(5999, 3999);
		send_pixel(5999, 0);
		send_pixel(0, 3999);
		await_drain();

		// Empty source: nothing can be in bounds.
		program_transform({32'h0000_8000, 32'h0001_0000, 32'h0, 32'h0000_8000,
			32'h0, 32'h0001_0000, 32'd0, 32'd0});
		send_pixel(0, 0);
		send_pixel(10, 10);
		await_drain();

		// One-pixel source.
		program_transform({32'h0000_8000, 32'h0001_0000, 32'h0, 32'h0000_8000,
			32'h0, 32'h0001_0000, 32'd1, 32'd1});
		send_pixel(0, 0);
		send_pixel(1, 0);
		await_drain();

		// Random phases, some of them run flat out on both sides.
		for (int p = 0; p < 6; p++) begin
			no_idle = ($urandom_range(0, 3) == 0);
			program_transform(random_transform());
			for (int i = 0; i < 25; i++) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					col = COL_W'($urandom_range(0, 511));
					row = ROW_W'($urandom_range(0, 511));
				end else if (pick < 9) begin
					col = COL_W'($urandom_range(0, 5999));
					row = ROW_W'($urandom_range(0, 3999));
				end else begin
					col = COL_W'($urandom);
					row = ROW_W'($urandom);
				end
				send_pixel(col, row);
			end
			await_drain();
		end
		no_idle = 1'b0;

		// Let any stray result surface before the verdict.
		repeat (20) @(posedge clk);
		$display("Remapped %0d output pixels under %0d transform settings;", pixels_sent,
			settings_used);
		$display("%0d channel results were compared with the prediction.", results_checked);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
